/* rtl/rlfw_pkg.sv */
`timescale 1ns / 1ps
// Package for the resource lock with FIFO waiters.
// Holds the queue sizing, the status and request-kind codes and shared types.
package rlfw_pkg;

  localparam int unsigned WAIT_DEPTH = 16;
  localparam int unsigned PtrW       = $clog2(WAIT_DEPTH);
  localparam int unsigned CntW       = $clog2(WAIT_DEPTH + 1);

  localparam logic [7:0] NO_OWNER = 8'hFF;

  // request kinds
  localparam logic [1:0] KIND_RESERVE = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_ADD     = 2'd2;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_SUSPEND = 3'd1,
    ST_YIELD   = 3'd2,
    ST_NEVER   = 3'd3,
    ST_INVALID = 3'd4,
    ST_FULL    = 3'd5,
    ST_DONE    = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] task_id;
    logic [7:0] units;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_flags_t;

endpackage

/* rtl/rlfw_queue.sv */
`timescale 1ns / 1ps
// Wait queue: ring of {task, units} entries in a synchronous memory.
// Depends on rlfw_pkg for depth, pointer widths and entry type.
module rlfw_queue import rlfw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  input  logic     pop_i,
  output q_entry_t head_o,
  output q_flags_t flags_o
);

  q_entry_t            mem [WAIT_DEPTH];
  q_entry_t            head_q;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    if (p == PtrW'(WAIT_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
      count_d  = count_q + 1'b1;
    end else if (pop_i) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // head entry is read every cycle; the lock never consumes it in the cycle
  // right after a push or pop, so the registered read is hidden
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    head_q <= mem[rd_ptr_q];
  end

  assign head_o        = head_q;
  assign flags_o.empty = (count_q == '0);
  assign flags_o.full  = (count_q == CntW'(WAIT_DEPTH));

endmodule

/* rtl/resource_lock_fifo_waiters.sv */
`timescale 1ns / 1ps
// Resource lock with unit count and FIFO wait queue (top level).
// Result path: a request is taken into the request registers when accepted,
// and the exec state loads the result register, waiting while a previous
// result is still stalled at the output. No new request is taken until the
// exec state is left, which also covers the registered queue head read.
// Reset: no owner, zero units, empty queue, max_units = 1; queue memory
// contents are not cleared.
module resource_lock_fifo_waiters import rlfw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] task_id_i,
  input  logic [7:0] units_i,
  input  logic       task_valid_i,
  input  logic       task_async_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic       resume_valid_o,
  output logic [7:0] resume_task_o,
  output logic [7:0] owner_now_o,
  output logic [7:0] units_now_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] max_units_q;
  logic [7:0] owner_q, owner_d;
  logic [7:0] avail_q, avail_d;

  // captured request
  logic [1:0] kind_q;
  logic [7:0] tid_q;
  logic [7:0] units_q;
  logic       tvalid_q;
  logic       async_q;

  // result register
  logic       out_valid_q;
  status_e    status_q, status_d;
  logic       rvalid_q, rvalid_d;
  logic [7:0] rtask_q, rtask_d;

  logic       accept;
  logic       exec_fire;
  logic       push, pop;
  q_entry_t   push_data;
  q_entry_t   head;
  q_flags_t   qflags;
  logic [8:0] sum;
  logic [7:0] clamped;
  logic       do_grant_check;
  logic [7:0] owner_mid;

  rlfw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .flags_o    (qflags)
  );

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign push_data = '{task_id: tid_q, units: units_q};

  // wide sum for make-available, zero add for release
  assign sum     = {1'b0, avail_q} + ((kind_q == KIND_ADD) ? {1'b0, units_q} : 9'd0);
  assign clamped = (sum > {1'b0, max_units_q}) ? max_units_q : sum[7:0];

  always_comb begin
    status_d       = ST_DONE;
    owner_d        = owner_q;
    avail_d        = avail_q;
    rvalid_d       = 1'b0;
    rtask_d        = '0;
    push           = 1'b0;
    pop            = 1'b0;
    do_grant_check = 1'b0;
    owner_mid      = owner_q;

    case (kind_q)
      KIND_RESERVE: begin
        if (units_q > max_units_q) begin
          status_d = ST_NEVER;
        end else if (!tvalid_q || tid_q == NO_OWNER) begin
          status_d = ST_INVALID;
        end else if (owner_q == NO_OWNER && units_q <= avail_q) begin
          owner_d  = tid_q;
          status_d = ST_GRANTED;
        end else if (qflags.full) begin
          status_d = ST_FULL;
        end else begin
          push     = exec_fire;
          status_d = async_q ? ST_YIELD : ST_SUSPEND;
        end
      end
      KIND_RELEASE: begin
        if (owner_q != NO_OWNER) begin
          owner_mid      = NO_OWNER;
          avail_d        = clamped;
          do_grant_check = 1'b1;
        end
      end
      KIND_ADD: begin
        avail_d        = clamped;
        do_grant_check = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_grant_check) begin
      owner_d = owner_mid;
      if (owner_mid == NO_OWNER && !qflags.empty && clamped >= head.units) begin
        owner_d  = head.task_id;
        rvalid_d = 1'b1;
        rtask_d  = head.task_id;
        pop      = exec_fire;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  if (exec_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_units_q <= 8'd1;
      owner_q     <= NO_OWNER;
      avail_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_units_q <= cfg_wdata_i;
      end
      if (exec_fire) begin
        owner_q     <= owner_d;
        avail_q     <= avail_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      tid_q    <= task_id_i;
      units_q  <= units_i;
      tvalid_q <= task_valid_i;
      async_q  <= task_async_i;
    end
    if (exec_fire) begin
      status_q <= status_d;
      rvalid_q <= rvalid_d;
      rtask_q  <= rtask_d;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign resume_valid_o = rvalid_q;
  assign resume_task_o  = rtask_q;
  assign owner_now_o    = owner_q;
  assign units_now_o    = avail_q;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Testbench for resource_lock_fifo_waiters: directed and random requests checked
// against a behavioral model of the lock, its unit count and its wait queue.
// Depends on rlfw_pkg and the resource_lock_fifo_waiters RTL.
module tb;
  import rlfw_pkg::*;

  // the kind code the block does not define; it must change nothing
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned HoldCycles = 60;

  typedef struct packed {
    status_e    status;
    logic       resume_valid;
    logic [7:0] resume_task;
    logic [7:0] owner_now;
    logic [7:0] units_now;
  } lock_result_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic [7:0] cfg_wdata_i  = 8'd0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [1:0] kind_i       = KIND_RELEASE;
  logic [7:0] task_id_i    = 8'd0;
  logic [7:0] units_i      = 8'd0;
  logic       task_valid_i = 1'b0;
  logic       task_async_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [2:0] status_o;
  logic       resume_valid_o;
  logic [7:0] resume_task_o;
  logic [7:0] owner_now_o;
  logic [7:0] units_now_o;

  // model of the lock
  logic [7:0]   lock_max    = 8'd1;
  logic [7:0]   lock_owner  = NO_OWNER;
  logic [7:0]   lock_units  = 8'd0;
  q_entry_t     lock_waiters[$];
  lock_result_t pending_results[$];

  int  n_errors      = 0;
  int  n_requests    = 0;
  int  n_resumes     = 0;
  int  n_full        = 0;
  int  n_limits      = 0;
  int  burst_left    = 0;
  bit  steady        = 1'b0;
  bit  rx_busy       = 1'b1;
  int  hold_requests = 0;
  int  holds_done    = 0;

  resource_lock_fifo_waiters uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .task_id_i     (task_id_i),
    .units_i       (units_i),
    .task_valid_i  (task_valid_i),
    .task_async_i  (task_async_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .resume_valid_o(resume_valid_o),
    .resume_task_o (resume_task_o),
    .owner_now_o   (owner_now_o),
    .units_now_o   (units_now_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Adds units (clamped at the limit), then hands the lock to the queue head
  // if nobody owns it and the head's request fits.
  function automatic bit settle_units(logic [7:0] add, output logic [7:0] granted);
    logic [8:0] sum;
    q_entry_t   head;
    granted = 8'd0;
    sum = {1'b0, lock_units} + {1'b0, add};
    if (sum > {1'b0, lock_max}) sum = {1'b0, lock_max};
    lock_units = sum[7:0];
    if (lock_owner != NO_OWNER || lock_waiters.size() == 0) return 1'b0;
    head = lock_waiters[0];
    if (lock_units < head.units) return 1'b0;
    void'(lock_waiters.pop_front());
    lock_owner = head.task_id;
    granted = head.task_id;
    return 1'b1;
  endfunction

  function automatic lock_result_t lock_step(logic [1:0] kind, logic [7:0] tid,
                                             logic [7:0] units, logic tv, logic ta);
    lock_result_t r;
    logic [7:0]   granted;
    r = '{status: ST_DONE, resume_valid: 1'b0, resume_task: 8'd0,
          owner_now: 8'd0, units_now: 8'd0};
    granted = 8'd0;
    case (kind)
      KIND_RESERVE: begin
        if (units > lock_max) begin
          r.status = ST_NEVER;
        end else if (!tv || tid == NO_OWNER) begin
          r.status = ST_INVALID;
        end else if (lock_owner == NO_OWNER && units <= lock_units) begin
          lock_owner = tid;
          r.status = ST_GRANTED;
        end else if (lock_waiters.size() >= WAIT_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          lock_waiters.push_back('{task_id: tid, units: units});
          r.status = ta ? ST_YIELD : ST_SUSPEND;
        end
      end
      KIND_RELEASE: begin
        if (lock_owner != NO_OWNER) begin
          lock_owner = NO_OWNER;
          r.resume_valid = settle_units(8'd0, granted);
        end
      end
      KIND_ADD: begin
        r.resume_valid = settle_units(units, granted);
      end
      default: ;
    endcase
    r.resume_task = r.resume_valid ? granted : 8'd0;
    r.owner_now = lock_owner;
    r.units_now = lock_units;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    lock_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, status_o);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 8'(want.status), 8'(status_o));
        compare_field("resume_valid", 8'(want.resume_valid), 8'(resume_valid_o));
        compare_field("resume_task", want.resume_task, resume_task_o);
        compare_field("owner_now", want.owner_now, owner_now_o);
        compare_field("units_now", want.units_now, units_now_o);
        if (resume_valid_o === 1'b1) n_resumes++;
        if (status_o == ST_FULL) n_full++;
      end
    end
  end

  // receiver: stall runs of random length, no stall while not busy, plus long hold-offs on demand
  initial begin
    forever begin
      if (holds_done != hold_requests) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
      end else if (!rx_busy) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  task automatic send_req(logic [1:0] kind, logic [7:0] tid, logic [7:0] units,
                          logic tv, logic ta);
    lock_result_t r;
    kind_i       <= kind;
    task_id_i    <= tid;
    units_i      <= units;
    task_valid_i <= tv;
    task_async_i <= ta;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = lock_step(kind, tid, units, tv, ta);
    pending_results.push_back(r);
    n_requests++;
  endtask

  task automatic pace_sender();
    if (burst_left == 0) begin
      if (!steady) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_max_units(logic [7:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lock_max = value;
    n_limits++;
  endtask

  task automatic send_random_req();
    int unsigned pick;
    logic [1:0]  kind;
    logic [7:0]  tid;
    logic [7:0]  units;
    logic        tv;
    logic        ta;
    pick  = $urandom_range(0, 99);
    kind  = KIND_RESERVE;
    tid   = 8'($urandom_range(0, 254));
    units = 8'($urandom_range(0, lock_max));
    tv    = 1'b1;
    ta    = 1'($urandom_range(0, 1));
    if (pick >= 50 && pick < 70) begin
      kind = KIND_RELEASE;
    end else if (pick >= 70 && pick < 88) begin
      kind  = KIND_ADD;
      units = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 4));
    end else if (pick >= 88) begin
      case (pick % 4)
        0: begin
          kind  = KIND_UNUSED;
          tid   = 8'($urandom_range(0, 255));
          units = 8'($urandom_range(0, 255));
        end
        1: tv = 1'b0;
        2: tid = NO_OWNER;
        default: units = (lock_max == 8'hFF) ? 8'hFF
                                             : 8'($urandom_range(lock_max + 1, 255));
      endcase
    end
    send_req(kind, tid, units, tv, ta);
  endtask

  // refusals at the reset limit of one unit, and the do-nothing requests
  task automatic test_refusals();
    send_req(KIND_RESERVE, 8'd3, 8'd2, 1'b1, 1'b0);
    send_req(KIND_RESERVE, NO_OWNER, 8'd9, 1'b0, 1'b0);   // too big wins over invalid
    send_req(KIND_RESERVE, 8'd4, 8'd1, 1'b0, 1'b0);
    send_req(KIND_RESERVE, NO_OWNER, 8'd0, 1'b1, 1'b0);
    send_req(KIND_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_req(KIND_RELEASE, 8'd0, 8'd0, 1'b1, 1'b0);      // no owner yet
  endtask

  task automatic test_grant_order();
    send_req(KIND_RESERVE, 8'd0, 8'd1, 1'b1, 1'b0);      // no units yet: waits
    send_req(KIND_RESERVE, 8'd254, 8'd0, 1'b1, 1'b1);    // fits, jumps the queue
    send_req(KIND_ADD, 8'd0, 8'd255, 1'b1, 1'b0);        // clamps to one
    send_req(KIND_RELEASE, 8'd0, 8'd0, 1'b1, 1'b0);
    send_req(KIND_RESERVE, 8'd128, 8'd1, 1'b1, 1'b1);
    send_req(KIND_RELEASE, 8'd0, 8'd0, 1'b1, 1'b0);
    send_req(KIND_RELEASE, 8'd0, 8'd0, 1'b1, 1'b0);
  endtask

  task automatic test_unit_limit();
    set_max_units(8'd255);
    send_req(KIND_ADD, 8'd0, 8'd255, 1'b1, 1'b0);        // wide sum past 255
    send_req(KIND_RESERVE, 8'd85, 8'd255, 1'b1, 1'b0);
    send_req(KIND_RESERVE, 8'd170, 8'd200, 1'b1, 1'b0);
    set_max_units(8'd0);
    send_req(KIND_ADD, 8'd0, 8'd0, 1'b1, 1'b0);          // lowered limit cuts the count
    send_req(KIND_RELEASE, 8'd0, 8'd0, 1'b1, 1'b0);      // head no longer fits
    send_req(KIND_RESERVE, 8'd1, 8'd0, 1'b1, 1'b0);
    set_max_units(8'd200);
    send_req(KIND_RELEASE, 8'd0, 8'd0, 1'b1, 1'b0);
    send_req(KIND_ADD, 8'd0, 8'd200, 1'b1, 1'b0);
    send_req(KIND_RELEASE, 8'd0, 8'd0, 1'b1, 1'b0);
  endtask

  task automatic test_queue_full();
    set_max_units(8'd255);
    if (lock_owner == NO_OWNER) send_req(KIND_RESERVE, 8'd9, 8'd0, 1'b1, 1'b0);
    while (lock_waiters.size() < WAIT_DEPTH) begin
      send_req(KIND_RESERVE, 8'($urandom_range(0, 254)), 8'($urandom_range(0, 255)), 1'b1,
               1'($urandom_range(0, 1)));
      pace_sender();
    end
    repeat (2) send_req(KIND_RESERVE, 8'($urandom_range(0, 254)), 8'd0, 1'b1, 1'b0);
    send_req(KIND_ADD, 8'd0, 8'd255, 1'b1, 1'b0);
    while (lock_owner != NO_OWNER) begin
      send_req(KIND_RELEASE, 8'd0, 8'd0, 1'b1, 1'b0);
      pace_sender();
    end
  endtask

  // receiver holds off while requests keep coming, then sender waits it out
  task automatic test_backpressure();
    hold_requests++;
    repeat (24) send_random_req();
    drain();
  endtask

  task automatic test_random();
    logic [7:0] limits[6];
    limits = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd16, 8'd0};
    limits[5] = 8'($urandom_range(0, 255));
    for (int p = 0; p < 6; p++) begin
      set_max_units(limits[p]);
      steady  = (p == 3);
      rx_busy = (p != 3);
      repeat (60) begin
        send_random_req();
        pace_sender();
      end
    end
    steady  = 1'b0;
    rx_busy = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_refusals();
    test_grant_order();
    test_unit_limit();
    test_queue_full();
    test_backpressure();
    test_random();
    drain();
    $display("Checked %0d requests under %0d unit limits: %0d waiters resumed,",
             n_requests, n_limits, n_resumes);
    $display("%0d requests refused on a full queue, %0d errors.", n_full, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
